>>> hw/rtl/mie_pkg.sv
// ----------------------------------------------------------------------------
// mie_pkg
// Shared types and constants for the extended Euclid modular inverse block.
// ----------------------------------------------------------------------------
package mie_pkg;

  // width of every stream field and of the modulus register
  localparam int unsigned FIELD_W = 31;

  // modulus after reset, the prime 1000000000 + 7
  localparam logic [FIELD_W-1:0] MODULUS_RESET = FIELD_W'(1000000000 + 7);

  // sequencer states of the shared divide/accumulate unit
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_UP,
    ST_DOWN,
    ST_FIX,
    ST_NEG,
    ST_DONE
  } state_t;

  // one result beat
  typedef struct packed {
    logic [FIELD_W-1:0] divisor;
    logic [FIELD_W-1:0] inverse;
  } res_t;

endpackage

>>> hw/rtl/mie_euclid_core.sv
// ----------------------------------------------------------------------------
// mie_euclid_core
// Iterative extended Euclid: one shift/compare/subtract unit computes each
// quotient bit by bit while the Bezout magnitude accumulates alongside.
// ----------------------------------------------------------------------------
module mie_euclid_core #(
  parameter int unsigned WORD_BITS = 31
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [WORD_BITS-1:0]    value,
  input  logic [WORD_BITS-1:0]    modulus,
  output logic                    idle,
  output logic                    res_valid,
  input  logic                    res_ack,
  output mie_pkg::res_t           res
);

  localparam int unsigned W = WORD_BITS;

  mie_pkg::state_t state_r, state_nxt;

  // remainder pair, shifted divisor, coefficient pair, shifted coefficient
  logic [W-1:0] r0_r, r0_nxt;
  logic [W-1:0] r1_r, r1_nxt;
  logic [W:0]   d_r, d_nxt;
  logic [W:0]   s0_r, s0_nxt;
  logic [W:0]   s1_r, s1_nxt;
  logic [W:0]   e_r, e_nxt;
  logic         neg_r, neg_nxt;

  // shared unit signals
  logic [W+1:0] d_dbl;
  logic         up_ok;
  logic         ge;
  logic [W-1:0] r0_sub;
  logic [W:0]   s0_add;
  logic         last_bit;
  logic [W:0]   m_ext;

  assign m_ext    = {1'b0, modulus};
  assign d_dbl    = {d_r, 1'b0};
  assign up_ok    = d_dbl <= {2'b00, r0_r};
  assign ge       = d_r <= {1'b0, r0_r};
  assign r0_sub   = ge ? (r0_r - d_r[W-1:0]) : r0_r;
  assign s0_add   = ge ? (s0_r + e_r) : s0_r;
  assign last_bit = d_r == {1'b0, r1_r};

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mie_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    r0_r  <= r0_nxt;
    r1_r  <= r1_nxt;
    d_r   <= d_nxt;
    s0_r  <= s0_nxt;
    s1_r  <= s1_nxt;
    e_r   <= e_nxt;
    neg_r <= neg_nxt;
  end

  // sequencer and shared unit control
  always_comb begin
    state_nxt = state_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    d_nxt     = d_r;
    s0_nxt    = s0_r;
    s1_nxt    = s1_r;
    e_nxt     = e_r;
    neg_nxt   = neg_r;
    idle      = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      mie_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          r0_nxt    = value;
          r1_nxt    = modulus;
          s0_nxt    = (W+1)'(1);
          s1_nxt    = '0;
          neg_nxt   = 1'b0;
          state_nxt = mie_pkg::ST_STEP;
        end
      end
      // start a quotient step or finish on a zero remainder
      mie_pkg::ST_STEP: begin
        if (r1_r == '0) begin
          state_nxt = mie_pkg::ST_FIX;
        end else begin
          d_nxt     = {1'b0, r1_r};
          e_nxt     = s1_r;
          state_nxt = mie_pkg::ST_UP;
        end
      end
      // align divisor under the remainder, one bit a cycle
      mie_pkg::ST_UP: begin
        if (up_ok) begin
          d_nxt = d_dbl[W:0];
          e_nxt = {e_r[W-1:0], 1'b0};
        end else begin
          state_nxt = mie_pkg::ST_DOWN;
        end
      end
      // restoring division, accumulate q * s1 into s0
      mie_pkg::ST_DOWN: begin
        if (last_bit) begin
          r0_nxt    = r1_r;
          r1_nxt    = r0_sub;
          s0_nxt    = s1_r;
          s1_nxt    = s0_add;
          neg_nxt   = !neg_r;
          state_nxt = mie_pkg::ST_STEP;
        end else begin
          r0_nxt = r0_sub;
          s0_nxt = s0_add;
          d_nxt  = {1'b0, d_r[W:1]};
          e_nxt  = {1'b0, e_r[W:1]};
        end
      end
      // reduce magnitude below the modulus
      mie_pkg::ST_FIX: begin
        if (modulus == '0) begin
          s0_nxt = '0;
        end else if (s0_r >= m_ext) begin
          s0_nxt = s0_r - m_ext;
        end
        state_nxt = mie_pkg::ST_NEG;
      end
      // apply the sign of the coefficient
      mie_pkg::ST_NEG: begin
        if (neg_r && (s0_r != '0)) begin
          s0_nxt = m_ext - s0_r;
        end
        state_nxt = mie_pkg::ST_DONE;
      end
      mie_pkg::ST_DONE: begin
        res_valid = 1'b1;
        if (res_ack) begin
          state_nxt = mie_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = mie_pkg::ST_IDLE;
      end
    endcase
  end

  assign res.inverse = mie_pkg::FIELD_W'(s0_r[W-1:0]);
  assign res.divisor = mie_pkg::FIELD_W'(r0_r);

`ifndef SYNTHESIS
  // a shifted divisor is never zero while dividing
  a_down_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mie_pkg::ST_DOWN) |-> (d_r != '0))
    else $error("divisor zero in division phase");

  // the divisor stays fixed while aligning
  a_up_r1_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mie_pkg::ST_UP) |=> (r1_r == $past(r1_r)))
    else $error("divisor changed while aligning");

  // a finished inverse lies below a nonzero modulus
  a_done_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mie_pkg::ST_DONE && modulus != '0) |-> (s0_r < m_ext))
    else $error("inverse not reduced");

  // a pending result holds until taken
  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !res_ack) |=> (res_valid && $stable(res)))
    else $error("result dropped before ack");
`endif

endmodule

>>> hw/rtl/modular_inverse_ext_euclid.sv
// ----------------------------------------------------------------------------
// modular_inverse_ext_euclid
// Modular inverse and gcd of a stream value against a configured modulus.
//
//  channel  dir  ports                   beat fields (low bit up)
//  in       in   in_tvalid/tready/tdata  value[30:0], pad[31]
//  out      out  out_tvalid/tready/tdata inverse[30:0], divisor[61:31], pad
//  cfg      in   cfg_we/cfg_wdata        modulus[30:0]
//
// One value at a time: each quotient step aligns the divisor and then divides
// bit by bit in the shift/subtract unit, followed by the last check and the
// final reduction and sign fix.
// in_tready rises again once the result moves into the output register,
// so a new value may start while the last result waits on out_tready.
// rst_n is synchronous; modulus resets to 1000000007.
// ----------------------------------------------------------------------------
module modular_inverse_ext_euclid #(
  parameter int unsigned WORD_BITS = 31
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // value[30:0], zero pad[31]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // inverse[30:0], divisor[61:31], zero pad
  input  logic        cfg_we,
  input  logic [30:0] cfg_wdata   // modulus[30:0]
);

  logic [mie_pkg::FIELD_W-1:0] modulus_r, modulus_nxt;
  logic                        out_valid_r, out_valid_nxt;
  mie_pkg::res_t               out_data_r, out_data_nxt;

  logic                        core_idle;
  logic                        core_valid;
  logic                        core_ack;
  mie_pkg::res_t               core_res;
  logic                        start;

  // modulus register
  assign modulus_nxt = cfg_we ? cfg_wdata : modulus_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mie_pkg::MODULUS_RESET;
    end else begin
      modulus_r <= modulus_nxt;
    end
  end

  // input beat handshake
  assign in_tready = core_idle;
  assign start     = in_tvalid && core_idle;

  mie_euclid_core #(
    .WORD_BITS (WORD_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .value     (WORD_BITS'(in_tdata[mie_pkg::FIELD_W-1:0])),
    .modulus   (WORD_BITS'(modulus_r)),
    .idle      (core_idle),
    .res_valid (core_valid),
    .res_ack   (core_ack),
    .res       (core_res)
  );

  // output register, loads when empty or being drained
  assign core_ack      = core_valid && (!out_valid_r || out_tready);
  assign out_valid_nxt = core_ack || (out_valid_r && !out_tready);
  assign out_data_nxt  = core_ack ? core_res : out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r.divisor, out_data_r.inverse};

endmodule
